/* design/fcp_pkg.sv */
package fcp_pkg;

  // Line and value sizing
  localparam int unsigned MAX_LINE   = 64;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned POS_W      = $clog2(MAX_LINE + 1);
  localparam int unsigned MAX_W      = 10;

  // Keyword table geometry
  localparam int unsigned KW_COUNT   = 6;
  localparam int unsigned KW_LEN_MAX = 8;
  localparam int unsigned KW_IDX_W   = $clog2(KW_LEN_MAX);
  localparam int unsigned KW_VREL    = 4;
  localparam int unsigned KW_VEL     = 5;

  // Result codes
  typedef enum logic [2:0] {
    CODE_VEL     = 3'd0,
    CODE_VREL    = 3'd1,
    CODE_VENTILA = 3'd2,
    CODE_EXAUST  = 3'd3,
    CODE_PARAR   = 3'd4,
    CODE_RETVEL  = 3'd5,
    CODE_UNKNOWN = 3'd6,
    CODE_BAD     = 3'd7
  } code_e;

  // Characters with a meaning of their own
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Keyword spelling, zero padded; the four exact words end in a star
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_LEN_MAX] = '{
    '{"V", "E", "N", "T", "I", "L", "A", "*"},
    '{"E", "X", "A", "U", "S", "T", "*", 8'h00},
    '{"P", "A", "R", "A", "R", "*", 8'h00, 8'h00},
    '{"R", "E", "T", "V", "E", "L", "*", 8'h00},
    '{"V", "R", "E", "L", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"V", "E", "L", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int unsigned KW_LEN [KW_COUNT] = '{8, 7, 6, 7, 4, 3};

  // Result handed from the parser core to the result register
  typedef struct packed {
    code_e                  code;
    logic                   direction;
    logic [VALUE_BITS-1:0]  value;
  } fcp_res_t;

endpackage

/* design/fan_command_line_parser.sv */
// Fan command parser. Takes one ASCII command byte per beat and gives one result beat
// for each byte marked end_of_line: a code, the held direction and the held speed
// value. Bytes are taken at one per cycle while the input does not stall; a byte waits in
// the input register and, once processed, its result is loaded into the result register.
// The input stalls only when the buffered byte closes a line and the result register
// still holds an untaken result.
// max_percent is written with cfg_we_i and should change only while no line is open.
module fan_command_line_parser import fcp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [MAX_W-1:0]       max_percent_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             char_in_i,
  input  logic                   end_of_line_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             result_code_o,
  output logic                   direction_o,
  output logic [VALUE_BITS-1:0]  speed_value_o
);

  logic                   in_valid_q;
  logic [7:0]             char_q;
  logic                   eol_q;
  logic [MAX_W-1:0]       max_q;
  logic                   out_valid_q;
  fcp_res_t               out_q;
  fcp_res_t               res;
  logic                   out_free;
  logic                   proc;
  logic                   in_accept;

  // Handshake: process a buffered byte unless it needs a full result slot
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && (!eol_q || out_free);
  assign in_stall_o = in_valid_q && !proc;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_W'(100);
    end else if (cfg_we_i) begin
      max_q <= max_percent_i;
    end
  end

  // Input register: load an accepted beat, drop a processed one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= char_in_i;
      eol_q  <= end_of_line_i;
    end
  end

  fcp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (proc),
    .char_i        (char_q),
    .eol_i         (eol_q),
    .max_percent_i (max_q),
    .res_o         (res)
  );

  // Result register: load on a line end, release when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && eol_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && eol_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_code_o = out_q.code;
  assign direction_o   = out_q.direction;
  assign speed_value_o = out_q.value;

`ifndef SYNTH
  // Input stalls only for a line end blocked by an untaken result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && eol_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  // A processed line end always shows a result next cycle
  a_eol_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && eol_q) |=> out_valid_o)
    else $error("line end produced no result");

  // A byte that is not a line end never fills the result slot
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(proc && eol_q)) |=> !out_valid_o)
    else $error("result appeared without a line end");

  // Accepted speed results never exceed the limit
  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_code_o == CODE_VEL || result_code_o == CODE_VREL))
      |-> (speed_value_o <= VALUE_BITS'(max_q)))
    else $error("speed result above limit");
`endif

endmodule

/* design/fcp_core.sv */
module fcp_core import fcp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       char_i,
  input  logic             eol_i,
  input  logic [MAX_W-1:0] max_percent_i,
  output fcp_res_t         res_o
);

  logic [POS_W-1:0]       pos_q, pos_d;
  logic [KW_COUNT-1:0]    flags_q, flags_d;
  code_e                  pend_q, pend_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic                   star_q, star_d;
  logic                   lbs_q, lbs_d;
  logic                   ovf_q, ovf_d;
  logic                   dir_set_q, dir_set_d;
  logic                   dir_sub_q, dir_sub_d;
  logic                   hdir_q, hdir_d;
  logic [VALUE_BITS-1:0]  hval_q, hval_d;

  logic                   absorb;
  logic                   is_digit;
  logic [VALUE_BITS+3:0]  acc_x10;
  logic [VALUE_BITS+3:0]  acc_sum;
  logic [VALUE_BITS-1:0]  acc_add;
  logic                   exact_hit;
  code_e                  exact_code;
  code_e                  code;

  // Decimal accumulate with saturation
  assign is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
  assign acc_sum  = acc_x10 + {{(VALUE_BITS){1'b0}}, char_i[3:0]};
  assign acc_add  = (|acc_sum[VALUE_BITS+3:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                        : acc_sum[VALUE_BITS-1:0];
  assign absorb   = pos_q < POS_W'(MAX_LINE);

  always_comb begin
    pos_d      = pos_q;
    flags_d    = flags_q;
    pend_d     = pend_q;
    acc_d      = acc_q;
    star_d     = star_q;
    lbs_d      = lbs_q;
    ovf_d      = ovf_q;
    dir_set_d  = dir_set_q;
    dir_sub_d  = dir_sub_q;
    hdir_d     = hdir_q;
    hval_d     = hval_q;
    exact_hit  = 1'b0;
    exact_code = CODE_UNKNOWN;
    code       = CODE_UNKNOWN;

    if (fire_i) begin
      if (!absorb) begin
        ovf_d = 1'b1;
      end else begin
        // Drop keywords that no longer match
        for (int k = 0; k < KW_COUNT; k++) begin
          if (flags_q[k]) begin
            if (pos_q < POS_W'(KW_LEN[k])) begin
              if (char_i != KW_TEXT[k][pos_q[KW_IDX_W-1:0]]) flags_d[k] = 1'b0;
            end else if (k < KW_VREL) begin
              flags_d[k] = 1'b0;
            end
          end
        end

        // VEL form: keyword, space, digits up to the star
        if (flags_d[KW_VEL]) begin
          if (pos_q == POS_W'(2)) begin
            pend_d = CODE_VEL;
          end else if (pos_q == POS_W'(3)) begin
            if (char_i != CHAR_SPACE) pend_d = CODE_BAD;
          end else if (pos_q >= POS_W'(4) && !star_d) begin
            if (char_i == CHAR_STAR) star_d = 1'b1;
            else if (is_digit) acc_d = acc_add;
            else pend_d = CODE_UNKNOWN;
          end
        end

        // VREL form: keyword, space or digit, sign, space, digits up to the star
        if (flags_d[KW_VREL]) begin
          if (pos_q == POS_W'(3)) begin
            pend_d = CODE_VREL;
          end else if (pos_q == POS_W'(4)) begin
            if (char_i == CHAR_STAR || (!is_digit && char_i != CHAR_SPACE)) pend_d = CODE_BAD;
          end else if (pos_q == POS_W'(5)) begin
            if (char_i == CHAR_PLUS) dir_set_d = 1'b1;
            else if (char_i == CHAR_MINUS) dir_sub_d = 1'b1;
            else pend_d = CODE_BAD;
          end else if (pos_q == POS_W'(6)) begin
            if (char_i != CHAR_SPACE) pend_d = CODE_UNKNOWN;
          end else if (pos_q >= POS_W'(7) && !star_d) begin
            if (char_i == CHAR_STAR) star_d = 1'b1;
            else if (is_digit) acc_d = acc_add;
            else pend_d = CODE_BAD;
          end
        end

        lbs_d = (char_i == CHAR_STAR);
        pos_d = pos_q + POS_W'(1);
      end

      // Close the line: pick the code, update held fields, clear line state
      if (eol_i) begin
        for (int k = KW_VREL - 1; k >= 0; k--) begin
          if (flags_d[k] && pos_q == POS_W'(KW_LEN[k] - 1)) begin
            exact_hit  = 1'b1;
            exact_code = code_e'(3'(k + 2));
          end
        end

        if (ovf_d) begin
          code = CODE_UNKNOWN;
        end else if (exact_hit) begin
          code = exact_code;
        end else if (lbs_d && ((flags_d[KW_VREL] && pos_q >= POS_W'(3)) ||
                               (flags_d[KW_VEL] && pos_q >= POS_W'(2)))) begin
          if (dir_set_d) hdir_d = 1'b0;
          else if (dir_sub_d) hdir_d = 1'b1;
          hval_d = acc_d;
          code   = pend_d;
          if (!star_d) code = CODE_BAD;
          if (acc_d > VALUE_BITS'(max_percent_i)) code = CODE_BAD;
        end

        pos_d     = '0;
        flags_d   = '1;
        pend_d    = CODE_UNKNOWN;
        acc_d     = '0;
        star_d    = 1'b0;
        lbs_d     = 1'b0;
        ovf_d     = 1'b0;
        dir_set_d = 1'b0;
        dir_sub_d = 1'b0;
      end
    end
  end

  assign res_o.code      = code;
  assign res_o.direction = hdir_d;
  assign res_o.value     = hval_d;

  // Line state and held fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      flags_q   <= '1;
      pend_q    <= CODE_UNKNOWN;
      acc_q     <= '0;
      star_q    <= 1'b0;
      lbs_q     <= 1'b0;
      ovf_q     <= 1'b0;
      dir_set_q <= 1'b0;
      dir_sub_q <= 1'b0;
      hdir_q    <= 1'b0;
      hval_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      flags_q   <= flags_d;
      pend_q    <= pend_d;
      acc_q     <= acc_d;
      star_q    <= star_d;
      lbs_q     <= lbs_d;
      ovf_q     <= ovf_d;
      dir_set_q <= dir_set_d;
      dir_sub_q <= dir_sub_d;
      hdir_q    <= hdir_d;
      hval_q    <= hval_d;
    end
  end

endmodule
